@@ rtl/lsch_pkg.sv @@
// lottery scheduler package: constants, codes and shared types
`timescale 1ns / 1ps
`default_nettype none

package lsch_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic [31:0] SEED_RESET = 32'd12345;
  localparam logic [4:0]  PCOUNT_RESET = 5'd1;
  localparam logic [4:0]  DONE_MAX   = 5'd31;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // configuration register indexes
  localparam logic CFG_PROCESS_COUNT = 1'b0;
  localparam logic CFG_RANDOM_SEED   = 1'b1;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  tickets;
    logic        started;
  } entry_t;

  typedef struct packed {
    logic        idle;
    logic [3:0]  winner_slot;
    logic [7:0]  winner_id;
    logic [15:0] tick_time;
    logic        first_dispatch;
    logic [15:0] resp_ticks;
    logic        finished;
    logic [15:0] tat_ticks;
    logic [15:0] wait_ticks;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/lsch_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/lottery_scheduler.sv @@
// lottery scheduler top level: entry table, sequencer and restoring divider
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_type slot proc_id arrival burst ticket_count
//  res     | out       | res_valid / res_stall  | idle winner_slot winner_id tick_time ... all_done
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index cfg_data
//
// a load goes from acceptance straight to output; a tick passes through ticket sum,
// generator multiply and add, divider steps, table scan, update and output; an idle tick
// goes to output after the sum or the scan; a new request is stalled until the sequencer
// is back in idle; the divider and the single table read port set most of a tick's length
// synchronous reset clears the control state and the table valid bits, no clearing pass
// a stalled result is held in the output register while the next item is taken

`timescale 1ns / 1ps
`default_nettype none

module lottery_scheduler
  import lsch_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [3:0]  slot,
  input  logic [7:0]  proc_id,
  input  logic [15:0] arrival,
  input  logic [15:0] burst,
  input  logic [7:0]  ticket_count,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic        idle,
  output logic [3:0]  winner_slot,
  output logic [7:0]  winner_id,
  output logic [15:0] tick_time,
  output logic        first_dispatch,
  output logic [15:0] resp_ticks,
  output logic        finished,
  output logic [15:0] tat_ticks,
  output logic [15:0] wait_ticks,
  output logic        all_done,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = ($clog2(MAX_ENTRIES + 1) > 5) ? $clog2(MAX_ENTRIES + 1) : 5;
  localparam int TW = $clog2(255 * MAX_ENTRIES + 1);
  localparam int EW = $bits(entry_t);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SUM  = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_ADD  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_SCAN = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration and global state
  logic [4:0]  process_count;
  logic [31:0] gen_state;
  logic [15:0] now_time;
  logic [4:0]  done_count;
  logic [MAX_ENTRIES-1:0] vld;

  // sequencer registers
  logic [CW-1:0] rd_idx;
  logic          pend;
  logic [IW-1:0] pend_idx;
  logic [TW-1:0] total;
  logic [TW-1:0] acc;
  logic [TW-1:0] winning;
  logic [TW-1:0] rem;
  logic [30:0]   div_sh;
  logic [4:0]    bit_cnt;
  logic [31:0]   prod;
  logic [15:0]   tick_t;
  logic [IW-1:0] pick_idx;
  entry_t        pick_ent;
  result_t       res_hold;

  // table ram
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [EW-1:0] ram_q;

  logic [CW-1:0] eff_n;
  logic [CW-1:0] pc_ext;
  logic          req_acc;
  logic          res_acc;
  logic          slot_ok;
  logic          out_load;
  entry_t        ent;
  logic          ent_elig;
  logic          rd_more;
  logic [TW-1:0] acc_sum;
  logic [TW:0]   div_r2;
  logic [TW-1:0] div_step;
  logic [31:0]   lcg_next;
  entry_t        load_ent;
  entry_t        upd_ent;
  logic [15:0]   now_sat;
  logic [15:0]   upd_rem;
  logic [15:0]   upd_tat;
  logic          upd_fin;
  result_t       upd_res;
  result_t       idle_res;
  result_t       load_res;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign res_acc   = res_valid && !res_stall;
  assign out_load  = (state == S_OUT) && (!res_valid || !res_stall);

  assign pc_ext  = CW'(process_count);
  assign eff_n   = (pc_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : pc_ext;
  assign slot_ok = (int'(slot) < MAX_ENTRIES);
  assign rd_more = (rd_idx < eff_n);

  // entries never loaded read as empty
  assign ent      = vld[pend_idx] ? entry_t'(ram_q) : '0;
  assign ent_elig = (ent.arrival <= now_time) && (ent.remaining != 16'd0);
  assign acc_sum  = acc + TW'(ent.tickets);

  // one restoring step of the remainder
  always_comb begin
    div_r2 = {rem, div_sh[30]};
    if (div_r2 >= {1'b0, total}) begin
      div_step = TW'(div_r2 - {1'b0, total});
    end else begin
      div_step = div_r2[TW-1:0];
    end
  end

  assign lcg_next = prod + LCG_ADD;
  assign now_sat  = (tick_t == 16'hffff) ? tick_t : tick_t + 16'd1;

  always_comb begin
    load_ent.id        = proc_id;
    load_ent.arrival   = arrival;
    load_ent.burst     = burst;
    load_ent.remaining = burst;
    load_ent.tickets   = ticket_count;
    load_ent.started   = 1'b0;
  end

  // winner bookkeeping
  always_comb begin
    upd_rem = pick_ent.remaining - 16'd1;
    upd_fin = (upd_rem == 16'd0);
    upd_tat = now_sat - pick_ent.arrival;

    upd_ent           = pick_ent;
    upd_ent.remaining = upd_rem;
    upd_ent.started   = 1'b1;

    upd_res                 = '0;
    upd_res.winner_slot     = 4'(pick_idx);
    upd_res.winner_id       = pick_ent.id;
    upd_res.tick_time       = tick_t;
    upd_res.first_dispatch  = !pick_ent.started;
    upd_res.resp_ticks      = pick_ent.started ? 16'd0 : tick_t - pick_ent.arrival;
    upd_res.finished        = upd_fin;
    if (upd_fin) begin
      upd_res.tat_ticks  = upd_tat;
      upd_res.wait_ticks = (upd_tat >= pick_ent.burst) ? upd_tat - pick_ent.burst : 16'd0;
    end

    idle_res           = '0;
    idle_res.idle      = 1'b1;
    idle_res.tick_time = tick_t;

    load_res      = '0;
    load_res.idle = 1'b1;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IW'(slot);
    ram_wdata = load_ent;
    if (state == S_UPD) begin
      ram_we    = 1'b1;
      ram_waddr = pick_idx;
      ram_wdata = upd_ent;
    end else if (req_acc && req_type == REQ_LOAD && slot_ok) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = ((state == S_SUM) || (state == S_SCAN)) && rd_more;

  lsch_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx[IW-1:0]),
    .rdata (ram_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      process_count <= PCOUNT_RESET;
      gen_state     <= SEED_RESET;
      now_time      <= 16'd0;
      done_count    <= 5'd0;
      vld           <= '0;
      res_valid     <= 1'b0;
      pend          <= 1'b0;
      rd_idx        <= '0;
      bit_cnt       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROCESS_COUNT: process_count <= cfg_data[4:0];
          CFG_RANDOM_SEED:   gen_state     <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_acc) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_acc) begin
            if (req_type == REQ_LOAD) begin
              if (slot_ok) begin
                vld[IW'(slot)] <= 1'b1;
                now_time       <= 16'd0;
                done_count     <= 5'd0;
              end
              state <= S_OUT;
            end else begin
              rd_idx <= '0;
              pend   <= 1'b0;
              state  <= S_SUM;
            end
          end
        end
        S_SUM: begin
          pend <= rd_more;
          if (rd_more) begin
            rd_idx <= rd_idx + CW'(1);
          end else if (!pend) begin
            if (total == '0) begin
              now_time <= now_sat;
              state    <= S_OUT;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          gen_state <= lcg_next;
          bit_cnt   <= 5'd30;
          state     <= S_DIV;
        end
        S_DIV: begin
          bit_cnt <= bit_cnt - 5'd1;
          if (bit_cnt == 5'd0) begin
            rd_idx <= '0;
            pend   <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend <= rd_more;
          if (rd_more) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (pend && ent_elig && acc_sum >= winning) begin
            state <= S_UPD;
          end else if (!rd_more && !pend) begin
            // no pick found: reported as an idle tick
            now_time <= now_sat;
            state    <= S_OUT;
          end
        end
        S_UPD: begin
          now_time <= now_sat;
          if (upd_fin && done_count < DONE_MAX) begin
            done_count <= done_count + 5'd1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        tick_t <= now_time;
        total  <= '0;
        if (req_acc && req_type == REQ_LOAD) begin
          res_hold <= load_res;
        end
      end
      S_SUM: begin
        if (pend && ent_elig) begin
          total <= total + TW'(ent.tickets);
        end
        if (!rd_more && !pend) begin
          res_hold <= idle_res;
        end
      end
      S_MUL: begin
        prod <= 32'(gen_state * LCG_MUL);
      end
      S_ADD: begin
        div_sh <= lcg_next[31:1];
        rem    <= '0;
      end
      S_DIV: begin
        rem    <= div_step;
        div_sh <= {div_sh[29:0], 1'b0};
        acc    <= '0;
        if (bit_cnt == 5'd0) begin
          winning <= div_step + TW'(1);
        end
      end
      S_SCAN: begin
        if (pend && ent_elig) begin
          acc <= acc_sum;
        end
        if (pend) begin
          pick_idx <= pend_idx;
          pick_ent <= ent;
        end
        if (!rd_more && !pend) begin
          res_hold <= idle_res;
        end
      end
      S_UPD: begin
        res_hold <= upd_res;
      end
      default: ;
    endcase

    if (ram_re) begin
      pend_idx <= rd_idx[IW-1:0];
    end

    if (out_load) begin
      idle           <= res_hold.idle;
      winner_slot    <= res_hold.winner_slot;
      winner_id      <= res_hold.winner_id;
      tick_time      <= res_hold.tick_time;
      first_dispatch <= res_hold.first_dispatch;
      resp_ticks     <= res_hold.resp_ticks;
      finished       <= res_hold.finished;
      tat_ticks      <= res_hold.tat_ticks;
      wait_ticks     <= res_hold.wait_ticks;
      all_done       <= (CW'(done_count) >= eff_n);
    end
  end

endmodule

`default_nettype wire
